// ----- design/shc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the crypt table generator for the string hash core
// used by shc_rom, shc_seed and table_driven_string_hash_core; no dependencies

package shc_pkg;

	localparam int unsigned HASH_TYPES_MAX = 5;
	localparam int unsigned SLICE_WORDS    = 256;
	localparam int unsigned TABLE_WORDS    = HASH_TYPES_MAX * SLICE_WORDS;

	localparam logic [31:0] SEED_A_START = 32'h07ED_7FED;
	localparam logic [31:0] SEED_B_START = 32'h0EEE_EEEE;
	localparam logic [31:0] SEED_B_INC   = 32'd3;

	localparam logic [31:0] GEN_START = 32'h0011_1111;
	localparam logic [31:0] GEN_MUL   = 32'd125;
	localparam logic [31:0] GEN_ADD   = 32'd3;
	localparam logic [31:0] GEN_MOD   = 32'h002A_AAAF;

	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_CASE    = 8'h20;

	typedef logic [31:0] crypt_word_t;
	typedef crypt_word_t crypt_table_t [TABLE_WORDS];

	// one key byte moving from the table read stage into the seed update
	typedef struct packed {
		logic fire;
		logic last;
		logic in_range;
	} shc_step_t;

	// evaluated at elaboration only: congruential fill, byte outer, type inner
	function automatic crypt_table_t build_crypt_table(input int unsigned ntypes);
		crypt_table_t tbl;
		logic [31:0]  s;
		logic [15:0]  hi;
		tbl = '{default: '0};
		s   = GEN_START;
		for (int unsigned b = 0; b < SLICE_WORDS; b++) begin
			for (int unsigned t = 0; t < ntypes; t++) begin
				s  = (s * GEN_MUL + GEN_ADD) % GEN_MOD;
				hi = s[15:0];
				s  = (s * GEN_MUL + GEN_ADD) % GEN_MOD;
				tbl[t * SLICE_WORDS + b] = {hi, s[15:0]};
			end
		end
		return tbl;
	endfunction

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
			r = c - CHAR_CASE;
		end
		return r;
	endfunction

endpackage

// ----- design/table_driven_string_hash_core.sv -----
`timescale 1ns / 1ps
// One key byte per cycle while the slave side is ready: a byte is taken, folded to upper
// case and used with its hash type to address the registered crypt table read; the seed
// pair updates from that table word in the seed update stage, and on the last byte the hash
// is registered onto the master side. Sustained rate is one byte per cycle, set by the seed
// recurrence fed from the table read port; the slave side stalls only while a finished hash
// waits and another last byte has reached the seed update. The table is a fixed read-only
// memory of HASH_TYPES*256 words, no fill pass after reset.
// depends on shc_pkg, shc_rom and shc_seed

module table_driven_string_hash_core #(
	parameter int unsigned HASH_TYPES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [7:0] key_byte, [10:8] hash_type, [15:11] zero
	input  logic        s_tlast,    // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata     // [31:0] hash_value
);

	localparam int unsigned DEPTH = HASH_TYPES * shc_pkg::SLICE_WORDS;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic        s_fire;
	logic [7:0]  ch_in;
	logic [2:0]  type_in;
	logic [10:0] addr_in;
	logic        in_range_in;

	logic        valid_s1;
	logic        last_s1;
	logic        in_range_s1;
	logic [7:0]  ch_s1;
	logic        s1_adv;
	logic        s1_fire;

	shc_pkg::crypt_word_t rom_word;
	shc_pkg::shc_step_t   step;
	logic [31:0]          seed_next;

	logic        out_valid_q;
	logic [31:0] hash_q;

	assign ch_in       = shc_pkg::fold_upper(s_tdata[7:0]);
	assign type_in     = s_tdata[10:8];
	assign addr_in     = {type_in, ch_in};
	assign in_range_in = ({29'b0, type_in} < HASH_TYPES);

	// update stage holds only when it carries a last byte and the result slot is full
	assign s1_adv   = !valid_s1 || !(last_s1 && out_valid_q && !m_tready);
	assign s1_fire  = valid_s1 && s1_adv;
	assign s_tready = s1_adv;
	assign s_fire   = s_tvalid && s_tready;

	shc_rom #(
		.HASH_TYPES(HASH_TYPES)
	) u_rom (
		.clk     (clk),
		.rd_en   (s_fire),
		.rd_addr (addr_in[AW-1:0]),
		.rd_data (rom_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= s_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			last_s1     <= s_tlast;
			in_range_s1 <= in_range_in;
			ch_s1       <= ch_in;
		end
	end

	assign step.fire     = s1_fire;
	assign step.last     = last_s1;
	assign step.in_range = in_range_s1;

	shc_seed u_seed (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.ch        (ch_s1),
		.word      (rom_word),
		.seed_next (seed_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			hash_q <= seed_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = hash_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && out_valid_q && !m_tready))
		else $error("slave side stalled without a waiting hash");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> out_valid_q)
		else $error("last byte did not produce a hash");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_fire && last_s1))
		else $error("hash shown without a completed key");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> $stable(hash_q))
		else $error("pending hash overwritten");

endmodule

// ----- design/shc_rom.sv -----
`timescale 1ns / 1ps
// crypt table memory: synchronous read, read data held when not enabled
// depends on shc_pkg for the table generator

module shc_rom #(
	parameter int unsigned HASH_TYPES = 5
) (
	input  logic                                        clk,
	input  logic                                        rd_en,
	input  logic [$clog2(HASH_TYPES*shc_pkg::SLICE_WORDS)-1:0] rd_addr,
	output shc_pkg::crypt_word_t                        rd_data
);

	localparam shc_pkg::crypt_table_t CRYPT_ROM = shc_pkg::build_crypt_table(HASH_TYPES);

	shc_pkg::crypt_word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= CRYPT_ROM[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/shc_seed.sv -----
`timescale 1ns / 1ps
// running seed pair and its registered update from the table word
// depends on shc_pkg for the step struct and start values

module shc_seed (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shc_pkg::shc_step_t   step,
	input  logic [7:0]           ch,
	input  shc_pkg::crypt_word_t word,
	output logic [31:0]          seed_next
);

	logic [31:0] seed_a_q;
	logic [31:0] seed_b_q;
	logic [31:0] word_eff;
	logic [31:0] na;
	logic [31:0] nb;

	// a type beyond the table reads as a zero word
	assign word_eff = step.in_range ? word : '0;
	assign na = word_eff ^ (seed_a_q + seed_b_q);
	assign nb = {24'b0, ch} + na + seed_b_q + {seed_b_q[26:0], 5'b0}
		+ shc_pkg::SEED_B_INC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_q <= shc_pkg::SEED_A_START;
			seed_b_q <= shc_pkg::SEED_B_START;
		end else if (step.fire) begin
			if (step.last) begin
				seed_a_q <= shc_pkg::SEED_A_START;
				seed_b_q <= shc_pkg::SEED_B_START;
			end else begin
				seed_a_q <= na;
				seed_b_q <= nb;
			end
		end
	end

	assign seed_next = na;

endmodule
